// ===== hw/rtl/adc_scan_block_averager_macros.svh =====
// Assertion macros used by the scan averager top level.
`ifndef ADC_SCAN_BLOCK_AVERAGER_MACROS_SVH
`define ADC_SCAN_BLOCK_AVERAGER_MACROS_SVH

`ifndef SYNTHESIS
`define ABAVG_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ABAVG_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ABAVG_ASSERT(name, prop, msg)
`define ABAVG_ASSERT_NEVER(name, cond, msg)
`endif

`endif

// ===== hw/rtl/abavg_pkg.sv =====
// Shared constants, types and command/status structs of the scan averager.
package abavg_pkg;

  localparam int NUM_SLOTS       = 5;
  localparam int SAMPLES_PER_AVG = 3;

  localparam int SAMPLE_W   = 12;
  localparam int SLOT_OUT_W = 3;

  localparam int DEPTH   = NUM_SLOTS * SAMPLES_PER_AVG;
  localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int ROUND_W = (SAMPLES_PER_AVG > 1) ? $clog2(SAMPLES_PER_AVG) : 1;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // The mean is taken as a multiply by a rounded-up reciprocal, which is exact
  // for every sum that fits in SUM_W bits.
  localparam int SUM_W   = $clog2(SAMPLES_PER_AVG * ((1 << SAMPLE_W) - 1) + 1);
  localparam int DIV_L   = $clog2(SAMPLES_PER_AVG);
  localparam int DIV_SH  = SUM_W + DIV_L;
  localparam int RECIP   = ((1 << DIV_SH) + SAMPLES_PER_AVG - 1) / SAMPLES_PER_AVG;
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int PROD_W  = SUM_W + RECIP_W;

  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [ROUND_W-1:0]  round_t;
  typedef logic [SAMPLE_W-1:0] sample_t;

  localparam slot_t  SLOT_LAST  = SLOT_W'(NUM_SLOTS - 1);
  localparam round_t ROUND_LAST = ROUND_W'(SAMPLES_PER_AVG - 1);

  typedef struct packed {
    logic   wr_en;
    logic   rd_en;
    logic   rd_first;
    slot_t  slot;
    round_t round;
    logic   mul_en;
    logic   ld_step;
    logic   ld_avg;
    slot_t  step_next_slot;
    logic   step_start;
    logic   step_busy;
    logic   last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/adc_scan_block_averager.sv =====
// Top level of the round-robin scan sampler with per-slot block averaging.
//
//   channel  direction  handshake                payload
//   in       input      in_valid_i / in_stall_o  sample_i
//   out      output     out_valid_o / out_stall_i
//                       next_slot_o, start_next_o, scan_in_progress_o,
//                       average_valid_o, avg_slot_o, average_o, last_o
//
// A sample that does not close a block is written and its beat loaded into the
// output register on the accepting edge.
// The sample that closes a block starts a sequence that sums, divides and emits
// the average of each slot in turn, bounded by the single read port of the
// sample store and the shared reciprocal multiplier.
// The sample store has no reset and holds nothing meaningful until written.
// A stalled output holds off new input only once the output register is full.
`include "adc_scan_block_averager_macros.svh"

module adc_scan_block_averager (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [abavg_pkg::SAMPLE_W-1:0]   sample_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [abavg_pkg::SLOT_OUT_W-1:0] next_slot_o,
  output logic                             start_next_o,
  output logic                             scan_in_progress_o,
  output logic                             average_valid_o,
  output logic [abavg_pkg::SLOT_OUT_W-1:0] avg_slot_o,
  output logic [abavg_pkg::SAMPLE_W-1:0]   average_o,
  output logic                             last_o
);

  abavg_pkg::cmd_t cmd;
  abavg_pkg::sts_t sts;

  abavg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  abavg_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .sample_i           (sample_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .next_slot_o        (next_slot_o),
    .start_next_o       (start_next_o),
    .scan_in_progress_o (scan_in_progress_o),
    .average_valid_o    (average_valid_o),
    .avg_slot_o         (avg_slot_o),
    .average_o          (average_o),
    .last_o             (last_o)
  );

  `ABAVG_ASSERT(a_load_into_free_reg, (cmd.ld_step || cmd.ld_avg) |-> sts.out_free, "result loaded into a full output register")
  `ABAVG_ASSERT_NEVER(a_store_port_conflict, cmd.wr_en && cmd.rd_en, "store written and read in one cycle")
  `ABAVG_ASSERT(a_only_averages_continue, (out_valid_o && !last_o) |-> average_valid_o, "non-final beat without an average")

endmodule

// ===== hw/rtl/abavg_dp.sv =====
// Datapath of the scan averager: sample store, accumulator, divider and result register.
module abavg_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  abavg_pkg::cmd_t                     cmd_i,
  output abavg_pkg::sts_t                     sts_o,
  input  logic [abavg_pkg::SAMPLE_W-1:0]      sample_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [abavg_pkg::SLOT_OUT_W-1:0]    next_slot_o,
  output logic                                start_next_o,
  output logic                                scan_in_progress_o,
  output logic                                average_valid_o,
  output logic [abavg_pkg::SLOT_OUT_W-1:0]    avg_slot_o,
  output logic [abavg_pkg::SAMPLE_W-1:0]      average_o,
  output logic                                last_o
);

  logic [abavg_pkg::ADDR_W-1:0]   addr;
  abavg_pkg::sample_t             mem_q [abavg_pkg::DEPTH];
  abavg_pkg::sample_t             rd_data_q;
  logic                           rd_vld_q;
  logic                           rd_first_q;
  logic [abavg_pkg::SUM_W-1:0]    acc_q;
  logic [abavg_pkg::SUM_W-1:0]    acc_d;
  logic [abavg_pkg::PROD_W-1:0]   prod_q;
  abavg_pkg::sample_t             avg;
  logic                           out_valid_q;
  logic [abavg_pkg::SLOT_OUT_W-1:0] next_slot_q;
  logic                           start_next_q;
  logic                           busy_q;
  logic                           avg_valid_q;
  logic [abavg_pkg::SLOT_OUT_W-1:0] avg_slot_q;
  abavg_pkg::sample_t             average_q;
  logic                           last_q;

  assign addr = abavg_pkg::ADDR_W'(abavg_pkg::ADDR_W'(cmd_i.slot) *
                                   abavg_pkg::ADDR_W'(abavg_pkg::SAMPLES_PER_AVG)) +
                abavg_pkg::ADDR_W'(cmd_i.round);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[addr] <= sample_i;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[addr];
    end
  end

  assign acc_d = (rd_first_q ? '0 : acc_q) + abavg_pkg::SUM_W'(rd_data_q);
  assign avg   = abavg_pkg::SAMPLE_W'(prod_q >> abavg_pkg::DIV_SH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q    <= 1'b0;
      rd_first_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_vld_q   <= cmd_i.rd_en;
      rd_first_q <= cmd_i.rd_first;
      if (cmd_i.ld_step || cmd_i.ld_avg) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      acc_q <= acc_d;
    end
    if (cmd_i.mul_en) begin
      prod_q <= abavg_pkg::PROD_W'(acc_q) * abavg_pkg::PROD_W'(abavg_pkg::RECIP);
    end
    if (cmd_i.ld_step) begin
      next_slot_q  <= abavg_pkg::SLOT_OUT_W'(cmd_i.step_next_slot);
      start_next_q <= cmd_i.step_start;
      busy_q       <= cmd_i.step_busy;
      avg_valid_q  <= 1'b0;
      avg_slot_q   <= '0;
      average_q    <= '0;
      last_q       <= 1'b1;
    end else if (cmd_i.ld_avg) begin
      next_slot_q  <= '0;
      start_next_q <= 1'b0;
      busy_q       <= 1'b0;
      avg_valid_q  <= 1'b1;
      avg_slot_q   <= abavg_pkg::SLOT_OUT_W'(cmd_i.slot);
      average_q    <= avg;
      last_q       <= cmd_i.last;
    end
  end

  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o        = out_valid_q;
  assign next_slot_o        = next_slot_q;
  assign start_next_o       = start_next_q;
  assign scan_in_progress_o = busy_q;
  assign average_valid_o    = avg_valid_q;
  assign avg_slot_o         = avg_slot_q;
  assign average_o          = average_q;
  assign last_o             = last_q;

endmodule

// ===== hw/rtl/abavg_ctrl.sv =====
// Controller of the scan averager: scan indices and the block-average sequencer.
module abavg_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  abavg_pkg::sts_t sts_i,
  output abavg_pkg::cmd_t cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SUM   = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_MUL   = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

  state_e                  state_q, state_d;
  abavg_pkg::slot_t        slot_q, slot_d;
  abavg_pkg::round_t       round_q, round_d;
  abavg_pkg::slot_t        avg_slot_q, avg_slot_d;
  abavg_pkg::round_t       tap_q, tap_d;
  logic                    accept;

  assign in_stall_o = !((state_q == ST_IDLE) && sts_i.out_free);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d    = state_q;
    slot_d     = slot_q;
    round_d    = round_q;
    avg_slot_d = avg_slot_q;
    tap_d      = tap_q;
    cmd_o       = '0;
    cmd_o.slot  = slot_q;
    cmd_o.round = round_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.wr_en = 1'b1;
          if (slot_q != abavg_pkg::SLOT_LAST) begin
            slot_d               = slot_q + abavg_pkg::SLOT_W'(1);
            cmd_o.ld_step        = 1'b1;
            cmd_o.step_next_slot = slot_q + abavg_pkg::SLOT_W'(1);
            cmd_o.step_start     = 1'b1;
            cmd_o.step_busy      = 1'b1;
          end else begin
            slot_d = '0;
            if (round_q != abavg_pkg::ROUND_LAST) begin
              round_d         = round_q + abavg_pkg::ROUND_W'(1);
              cmd_o.ld_step   = 1'b1;
              cmd_o.step_busy = 1'b1;
            end else begin
              round_d    = '0;
              avg_slot_d = '0;
              tap_d      = '0;
              state_d    = ST_SUM;
            end
          end
        end
      end
      ST_SUM: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_first = (tap_q == '0);
        cmd_o.slot     = avg_slot_q;
        cmd_o.round    = tap_q;
        if (tap_q == abavg_pkg::ROUND_LAST) begin
          state_d = ST_DRAIN;
        end else begin
          tap_d = tap_q + abavg_pkg::ROUND_W'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.slot = avg_slot_q;
        cmd_o.last = (avg_slot_q == abavg_pkg::SLOT_LAST);
        if (sts_i.out_free) begin
          cmd_o.ld_avg = 1'b1;
          if (avg_slot_q == abavg_pkg::SLOT_LAST) begin
            state_d = ST_IDLE;
          end else begin
            avg_slot_d = avg_slot_q + abavg_pkg::SLOT_W'(1);
            tap_d      = '0;
            state_d    = ST_SUM;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      slot_q     <= '0;
      round_q    <= '0;
      avg_slot_q <= '0;
      tap_q      <= '0;
    end else begin
      state_q    <= state_d;
      slot_q     <= slot_d;
      round_q    <= round_d;
      avg_slot_q <= avg_slot_d;
      tap_q      <= tap_d;
    end
  end

endmodule
